FILE: src/imu_sample_scale_and_timestamp_core_defines.svh
// ----------------------------------------------------------------------------
// IMU sample scale and timestamp core: assertion macros
// Shared assertion helpers for the checker of the core.
// ----------------------------------------------------------------------------
`ifndef IMU_SAMPLE_SCALE_AND_TIMESTAMP_CORE_DEFINES_SVH
`define IMU_SAMPLE_SCALE_AND_TIMESTAMP_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define IMU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the core clock and reset.
`define IMU_ASSERT(label, prop, msg) `IMU_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: src/imu_sst_pkg.sv
// ----------------------------------------------------------------------------
// IMU sample scale and timestamp package
// Types, register codes and fixed-point constants shared by the core.
// ----------------------------------------------------------------------------
package imu_sst_pkg;

  localparam int unsigned StampLimitDefault = 812;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [15:0] UnwrapGap      = 16'd10;
  localparam logic [19:0] TickPeriodInit = 20'd49020;

  // Gyro scale factors: pi/28800 and pi/7200 in Q48, result taken in Q24.
  localparam logic [36:0] GyroFineQ48   = 37'd30704156910;
  localparam logic [36:0] GyroCoarseQ48 = 37'd122816627639;
  localparam logic [53:0] GyroHalf      = 54'd8388608;

  // Accel scale count * 98015 * 2^24 / 40e6, rounded, is rewritten as
  // count * 41110 + (count * 7354 + 7812) / 15625 with a floor division.
  localparam logic [15:0] AccelWhole = 16'd41110;
  localparam logic [12:0] AccelFrac  = 13'd7354;
  localparam logic [12:0] AccelRound = 13'd7812;
  localparam logic [13:0] AccelDiv   = 14'd15625;
  localparam logic [28:0] AccelRecip = 29'd281474976;  // floor(2^42 / 15625)
  localparam int unsigned AccelShift = 42;

  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_GYRO_MODE   = 2'd1,
    CFG_TICK_PERIOD = 2'd2,
    CFG_START_TIME  = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    GYRO_UNSET  = 2'd0,
    GYRO_FINE   = 2'd1,
    GYRO_COARSE = 2'd2,
    GYRO_ZERO   = 2'd3
  } gyro_mode_e;

  typedef enum logic [1:0] {
    STATUS_FIRST  = 2'd0,
    STATUS_NORMAL = 2'd1,
    STATUS_ERROR  = 2'd2
  } status_e;

  typedef struct packed {
    logic              enable;
    gyro_mode_e        gyro_mode;
    logic [19:0]       tick_period_ns;
    logic [62:0]       start_time_ns;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic [15:0]        tick_stamp;
    logic [31:0]        frame_number;
  } imu_in_t;

  typedef struct packed {
    logic signed [31:0] gyro_x_rad;
    logic signed [31:0] gyro_y_rad;
    logic signed [31:0] gyro_z_rad;
    logic signed [31:0] accel_x_ms2;
    logic signed [31:0] accel_y_ms2;
    logic signed [31:0] accel_z_ms2;
    logic [62:0]        sample_time_ns;
    logic [35:0]        delta_ns;
    logic [31:0]        sequence_res;
    status_e            status;
  } imu_out_t;

  // One classified frame on its way from the front end to the datapath.
  typedef struct packed {
    logic [2:0][15:0] gyro_raw;
    logic [2:0][15:0] accel_raw;
    logic [31:0]      frame_number;
    logic [15:0]      diff;
    status_e          status;
  } entry_t;

endpackage

FILE: src/imu_sst_front.sv
// ----------------------------------------------------------------------------
// IMU sample front end
// Accepts frames, drops them when disabled or with the gyro mode unset, and unwraps the tick stamp.
// ----------------------------------------------------------------------------
module imu_sst_front #(
  parameter int unsigned StampLimit = imu_sst_pkg::StampLimitDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imu_sst_pkg::cfg_t    cfg_i,
  input  logic                 in_valid_i,
  input  imu_sst_pkg::imu_in_t in_data_i,
  input  logic                 full_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output imu_sst_pkg::entry_t  entry_o
);
  import imu_sst_pkg::*;

  localparam logic [15:0] Limit = 16'(StampLimit);

  logic        first_q, first_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] largest_q, largest_d;
  logic [15:0] largest_new;
  logic [15:0] stamp;
  logic [15:0] diff;
  status_e     status;
  logic        run;

  assign stamp      = in_data_i.tick_stamp;
  assign in_stall_o = full_i;
  assign run        = in_valid_i && !full_i && cfg_i.enable && (cfg_i.gyro_mode != GYRO_UNSET);
  assign push_o     = run;

  always_comb begin
    first_d     = first_q;
    prev_d      = prev_q;
    largest_d   = largest_q;
    diff        = '0;
    status      = STATUS_FIRST;
    largest_new = (stamp > largest_q) ? stamp : largest_q;
    if (first_q) begin
      status = STATUS_FIRST;
      if (run) begin
        first_d = 1'b0;
      end
    end else if (stamp > Limit) begin
      status = STATUS_ERROR;
    end else begin
      status = STATUS_NORMAL;
      // A stamp that went backwards is treated as a wrap past the largest one seen.
      if (stamp > prev_q) begin
        diff = stamp - prev_q;
      end else if (stamp < prev_q) begin
        diff = largest_new - prev_q + UnwrapGap + stamp;
      end
      if (run) begin
        largest_d = largest_new;
        prev_d    = stamp;
      end
    end
  end

  always_comb begin
    entry_o.gyro_raw[0]  = in_data_i.gyro_x_raw;
    entry_o.gyro_raw[1]  = in_data_i.gyro_y_raw;
    entry_o.gyro_raw[2]  = in_data_i.gyro_z_raw;
    entry_o.accel_raw[0] = in_data_i.accel_x_raw;
    entry_o.accel_raw[1] = in_data_i.accel_y_raw;
    entry_o.accel_raw[2] = in_data_i.accel_z_raw;
    entry_o.frame_number = in_data_i.frame_number;
    entry_o.diff         = diff;
    entry_o.status       = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 1'b1;
      prev_q    <= 16'hFFFF;
      largest_q <= '0;
    end else begin
      first_q   <= first_d;
      prev_q    <= prev_d;
      largest_q <= largest_d;
    end
  end

endmodule

FILE: src/imu_sst_queue.sv
// ----------------------------------------------------------------------------
// IMU sample queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
module imu_sst_queue #(
  parameter int unsigned Depth = imu_sst_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  imu_sst_pkg::entry_t entry_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                full_o,
  output imu_sst_pkg::entry_t entry_o
);
  import imu_sst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: src/imu_sst_back.sv
// ----------------------------------------------------------------------------
// IMU sample datapath
// Four-stage pipeline that scales samples and accumulates the frame clock.
// ----------------------------------------------------------------------------
module imu_sst_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imu_sst_pkg::cfg_t     cfg_i,
  input  logic                  q_valid_i,
  input  imu_sst_pkg::entry_t   q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output imu_sst_pkg::imu_out_t out_data_o
);
  import imu_sst_pkg::*;

  logic advance;

  // Stage 1: magnitudes and products.
  logic             s1_valid_q;
  logic [2:0]       s1_gneg_q, s1_aneg_q;
  logic [2:0][52:0] s1_gprod_q;
  logic [2:0][31:0] s1_abase_q;
  logic [2:0][27:0] s1_av_q;
  logic [35:0]      s1_delta_q;
  status_e          s1_status_q;
  logic [31:0]      s1_frame_q;

  // Stage 2: gyro rounding, accel reciprocal product, clock update.
  logic             s2_valid_q;
  logic [2:0]       s2_gneg_q, s2_aneg_q;
  logic [2:0][31:0] s2_gmag_q;
  logic [2:0][31:0] s2_abase_q;
  logic [2:0][27:0] s2_av_q;
  logic [2:0][56:0] s2_qprod_q;
  logic [62:0]      s2_time_q;
  logic [35:0]      s2_delta_q;
  status_e          s2_status_q;
  logic [31:0]      s2_frame_q;

  // Stage 3: quotient estimate and remainder, gyro sign.
  logic             s3_valid_q;
  logic [2:0]       s3_aneg_q;
  logic [2:0][31:0] s3_gyro_q;
  logic [2:0][31:0] s3_abase_q;
  logic [2:0][14:0] s3_qest_q;
  logic [2:0][14:0] s3_rem_q;
  logic [62:0]      s3_time_q;
  logic [35:0]      s3_delta_q;
  status_e          s3_status_q;
  logic [31:0]      s3_frame_q;

  // Stage 4: output register.
  logic             s4_valid_q;
  imu_out_t         out_q;

  logic [63:0]      clock_q, clock_d;
  logic [36:0]      gyro_k;

  logic [2:0][15:0] gmag, amag;
  logic [2:0][52:0] gprod;
  logic [2:0][31:0] abase;
  logic [2:0][27:0] av;
  logic [2:0][53:0] grnd;
  logic [2:0][56:0] qprod;
  logic [2:0][31:0] gyro_s;
  logic [2:0][14:0] qest;
  logic [2:0][14:0] rem;
  logic [2:0][31:0] amag4;
  logic [2:0][31:0] accel_s;

  // The whole pipeline holds while a finished result waits at the output.
  assign advance     = !(s4_valid_q && out_stall_i);
  assign q_pop_o     = advance && q_valid_i;
  assign out_valid_o = s4_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (cfg_i.gyro_mode)
      GYRO_FINE:   gyro_k = GyroFineQ48;
      GYRO_COARSE: gyro_k = GyroCoarseQ48;
      default:     gyro_k = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gmag[i]  = q_entry_i.gyro_raw[i][15] ? (16'd0 - q_entry_i.gyro_raw[i])
                                           : q_entry_i.gyro_raw[i];
      amag[i]  = q_entry_i.accel_raw[i][15] ? (16'd0 - q_entry_i.accel_raw[i])
                                            : q_entry_i.accel_raw[i];
      gprod[i] = 53'(gmag[i]) * 53'(gyro_k);
      abase[i] = 32'(amag[i]) * 32'(AccelWhole);
      av[i]    = 28'(amag[i]) * 28'(AccelFrac) + 28'(AccelRound);
      grnd[i]  = 54'(s1_gprod_q[i]) + GyroHalf;
      qprod[i] = 57'(s1_av_q[i]) * 57'(AccelRecip);
      gyro_s[i] = s2_gneg_q[i] ? (32'd0 - s2_gmag_q[i]) : s2_gmag_q[i];
      qest[i]  = s2_qprod_q[i][AccelShift +: 15];
      rem[i]   = 15'(s2_av_q[i] - 28'(qest[i]) * 28'(AccelDiv));
      // The estimate is low by at most one, so one correction step suffices.
      amag4[i] = s3_abase_q[i] + 32'(s3_qest_q[i])
               + 32'(s3_rem_q[i] >= 15'(AccelDiv));
      accel_s[i] = s3_aneg_q[i] ? (32'd0 - amag4[i]) : amag4[i];
    end
  end

  always_comb begin
    clock_d = clock_q;
    if (advance && s1_valid_q) begin
      case (s1_status_q)
        STATUS_FIRST:  clock_d = {1'b0, cfg_i.start_time_ns};
        STATUS_NORMAL: clock_d = clock_q + 64'(s1_delta_q);
        default:       clock_d = clock_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      clock_q    <= '0;
    end else begin
      clock_q <= clock_d;
      if (advance) begin
        s1_valid_q <= q_valid_i;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s1_gneg_q[i]  <= q_entry_i.gyro_raw[i][15];
        s1_aneg_q[i]  <= q_entry_i.accel_raw[i][15];
        s1_gprod_q[i] <= gprod[i];
        s1_abase_q[i] <= abase[i];
        s1_av_q[i]    <= av[i];

        s2_gmag_q[i]  <= 32'(grnd[i][53:24]);
        s2_abase_q[i] <= s1_abase_q[i];
        s2_av_q[i]    <= s1_av_q[i];
        s2_qprod_q[i] <= qprod[i];

        s3_gyro_q[i]  <= gyro_s[i];
        s3_abase_q[i] <= s2_abase_q[i];
        s3_qest_q[i]  <= qest[i];
        s3_rem_q[i]   <= rem[i];
      end
      s1_delta_q  <= 36'(q_entry_i.diff) * 36'(cfg_i.tick_period_ns);
      s1_status_q <= q_entry_i.status;
      s1_frame_q  <= q_entry_i.frame_number;

      s2_gneg_q   <= s1_gneg_q;
      s2_aneg_q   <= s1_aneg_q;
      s2_time_q   <= clock_d[62:0];
      s2_delta_q  <= (s1_status_q == STATUS_NORMAL) ? s1_delta_q : '0;
      s2_status_q <= s1_status_q;
      s2_frame_q  <= s1_frame_q;

      s3_aneg_q   <= s2_aneg_q;
      s3_time_q   <= s2_time_q;
      s3_delta_q  <= s2_delta_q;
      s3_status_q <= s2_status_q;
      s3_frame_q  <= s2_frame_q;

      out_q.gyro_x_rad     <= s3_gyro_q[0];
      out_q.gyro_y_rad     <= s3_gyro_q[1];
      out_q.gyro_z_rad     <= s3_gyro_q[2];
      out_q.accel_x_ms2    <= accel_s[0];
      out_q.accel_y_ms2    <= accel_s[1];
      out_q.accel_z_ms2    <= accel_s[2];
      out_q.sample_time_ns <= s3_time_q;
      out_q.delta_ns       <= s3_delta_q;
      out_q.sequence_res   <= s3_frame_q;
      out_q.status         <= s3_status_q;
    end
  end

endmodule

FILE: src/imu_sample_scale_and_timestamp_core.sv
// ----------------------------------------------------------------------------
// IMU sample scale and timestamp core
// Scales raw gyro and accel counts to Q7.24 and rebuilds absolute frame time.
// ----------------------------------------------------------------------------
// The core takes one raw IMU frame per clock when not stalled and returns at
// most one result per frame, in order. Accepted frames pass through the queue
// and the datapath stage registers. The sustained rate is one frame per cycle
// while the output is not stalled; the stamp unwrap in the front end and the
// 64-bit clock accumulator in the datapath are each updated once per frame. A
// queue of QueueDepth entries lets the front end keep accepting while the
// output stalls; in_stall_o rises only when that queue is full. Frames that
// arrive while disabled or with the gyro mode unset are taken and dropped
// without a result. Registers are written through the configuration port,
// which is always ready, and must only be changed while the core is idle.
module imu_sample_scale_and_timestamp_core #(
  parameter int unsigned StampLimit = imu_sst_pkg::StampLimitDefault,
  parameter int unsigned QueueDepth = imu_sst_pkg::QueueDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  imu_sst_pkg::imu_in_t    in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output imu_sst_pkg::imu_out_t   out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  imu_sst_pkg::cfg_index_e cfg_index_i,
  input  logic [62:0]             cfg_data_i
);
  import imu_sst_pkg::*;

  cfg_t   cfg_q;
  logic   push, full, q_valid, q_pop;
  entry_t push_entry, q_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.gyro_mode      <= GYRO_UNSET;
      cfg_q.tick_period_ns <= TickPeriodInit;
      cfg_q.start_time_ns  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE:      cfg_q.enable         <= cfg_data_i[0];
        CFG_GYRO_MODE:   cfg_q.gyro_mode      <= gyro_mode_e'(cfg_data_i[1:0]);
        CFG_TICK_PERIOD: cfg_q.tick_period_ns <= cfg_data_i[19:0];
        CFG_START_TIME:  cfg_q.start_time_ns  <= cfg_data_i;
        default:         cfg_q                <= cfg_q;
      endcase
    end
  end

  imu_sst_front #(
    .StampLimit(StampLimit)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  imu_sst_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (full),
    .entry_o (q_entry)
  );

  imu_sst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/imu_sst_checker.sv
// ----------------------------------------------------------------------------
// IMU sample scale and timestamp checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "imu_sample_scale_and_timestamp_core_defines.svh"

module imu_sst_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input imu_sst_pkg::imu_in_t    in_data_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input imu_sst_pkg::imu_out_t   out_data_o,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input imu_sst_pkg::cfg_index_e cfg_index_i,
  input logic [62:0]             cfg_data_i
);
  import imu_sst_pkg::*;

  // A stalled result must stay in place until it is taken.
  `IMU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // A stalled input transaction must stay in place as well.
  `IMU_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i), "input changed while stalled")

  // First frames and stamp errors add no time.
  `IMU_ASSERT(a_zero_delta, out_valid_o && (out_data_o.status == STATUS_FIRST || out_data_o.status == STATUS_ERROR) |-> out_data_o.delta_ns == '0, "nonzero delta on first or error frame")

  // Back-to-back normal results: the clock advances by exactly the reported delta.
  `IMU_ASSERT(a_time_chain, (out_valid_o && !out_stall_i) ##1 (out_valid_o && out_data_o.status == STATUS_NORMAL) |-> out_data_o.sample_time_ns == 63'($past(out_data_o.sample_time_ns) + 63'(out_data_o.delta_ns)), "clock did not advance by delta")

  // A stamp error right after another result leaves the clock unchanged.
  `IMU_ASSERT(a_error_hold, (out_valid_o && !out_stall_i) ##1 (out_valid_o && out_data_o.status == STATUS_ERROR) |-> out_data_o.sample_time_ns == $past(out_data_o.sample_time_ns), "clock moved on stamp error")

endmodule

bind imu_sample_scale_and_timestamp_core imu_sst_checker u_checker (.*);
